// ===== rtl/tls_client_hello_sni_extractor_top_macros.svh =====
// Assertion macros for the SNI extractor.
`ifndef TLS_CLIENT_HELLO_SNI_EXTRACTOR_TOP_MACROS_SVH
`define TLS_CLIENT_HELLO_SNI_EXTRACTOR_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define TCSX_ASSERT_IMP(lbl, ck, rn, a, b) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (a) |-> (b)) else $error("%m");
`define TCSX_ASSERT_NXT(lbl, ck, rn, a, b) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (a) |=> (b)) else $error("%m");
`else
`define TCSX_ASSERT_IMP(lbl, ck, rn, a, b)
`define TCSX_ASSERT_NXT(lbl, ck, rn, a, b)
`endif
`endif

// ===== rtl/tcsx_pkg.sv =====
// Shared types and constants for the SNI extractor.
package tcsx_pkg;
	localparam int NAME_MAX = 127;
	localparam logic [7:0] CT_HANDSHAKE = 8'h16;
	localparam logic [7:0] HS_CLIENT_HELLO = 8'h01;
	localparam logic [15:0] EXT_ESNI = 16'hffce;
	localparam logic [15:0] EXT_SNI = 16'h0000;
	localparam logic [16:0] POS_MAX = 17'h1ffff;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_REJECT = 2'd1;
	localparam logic [1:0] ST_TRUNC = 2'd2;

	localparam logic KIND_NAME = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	localparam logic [1:0] REG_DTLS = 2'd0;
	localparam logic [1:0] REG_DETECT = 2'd1;

	typedef enum logic [3:0] {
		PH_HDR = 4'd0, PH_SID = 4'd1, PH_CH = 4'd2, PH_CL = 4'd3, PH_COMP = 4'd4,
		PH_EH = 4'd5, PH_EL = 4'd6, PH_IH = 4'd7, PH_IL = 4'd8, PH_LH = 4'd9,
		PH_LL = 4'd10, PH_NH = 4'd11, PH_NL = 4'd12, PH_NAME = 4'd13, PH_DONE = 4'd14
	} phase_t;

	// what one byte produced: optional name word, optional verdict word
	typedef struct packed {
		logic       name_v;
		logic [7:0] name_char;
		logic       name_end;
		logic       verd_v;
		logic       tls;
		logic       esni;
		logic [1:0] status;
	} rec_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;
endpackage

// ===== rtl/tls_client_hello_sni_extractor_top.sv =====
// A result record enters the queue when its payload word is accepted and is offered from the queue head.
// Throughput: one payload word per cycle while the queue is not full; a final name byte that ends the packet
// yields two words from one queued record, so a full two-entry queue can stall input.
// Reset (arst_n low, asynchronous): parser to record header, registers to 0 except the
// extension cursor (2), queue empty. Parser state also returns to reset after each verdict.
`include "tls_client_hello_sni_extractor_top_macros.svh"
module tls_client_hello_sni_extractor_top import tcsx_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // payload_byte[7:0], packet_len[23:8]
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // name_char, name_end, tls_seen, esni_seen, verdict_status
	output logic        m_tuser,  // item_kind
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic        cfg_data
);
	q_stat_t stat;
	rec_t rec, head;
	logic push, pop, in_fire;

	assign cfg_ready = 1'b1;
	assign s_tready = !stat.full;
	assign in_fire = s_tvalid && s_tready;

	tcsx_front u_front (
		.clk, .arst_n, .in_fire,
		.b(s_tdata[7:0]), .plen(s_tdata[23:8]), .last(s_tlast),
		.cfg_fire(cfg_valid && cfg_ready), .cfg_index, .cfg_data,
		.rec_push(push), .rec
	);

	tcsx_queue u_queue (.clk, .arst_n, .push, .din(rec), .pop, .head, .stat);

	tcsx_back u_back (
		.clk, .arst_n, .head, .stat, .pop,
		.m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast
	);

	`TCSX_ASSERT_IMP(a_verdict_last, clk, arst_n, m_tvalid && m_tuser == KIND_VERDICT, m_tlast)
	`TCSX_ASSERT_IMP(a_name_clean, clk, arst_n, m_tvalid && m_tuser == KIND_NAME, m_tdata[12:9] == 4'd0)
	`TCSX_ASSERT_NXT(a_split_holds, clk, arst_n, m_tvalid && m_tready && !m_tlast, m_tvalid && m_tuser == KIND_VERDICT)
endmodule

// ===== rtl/tcsx_front.sv =====
// Byte parser: walks record, ClientHello and extensions, builds result records.
module tcsx_front import tcsx_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_fire,
	input  logic [7:0]  b,
	input  logic [15:0] plen,
	input  logic        last,
	input  logic        cfg_fire,
	input  logic [1:0]  cfg_index,
	input  logic        cfg_data,
	output logic        rec_push,
	output rec_t        rec
);
	logic dtls_q, detect_q;
	logic [16:0] pos_q, pos_n;
	phase_t phase_q, phase_n;
	logic [15:0] rl_q, rl_n;
	logic [17:0] fcur_q, fcur_n;
	logic [15:0] tot_q, tot_n;
	logic [17:0] ecur_q, ecur_n;
	logic [15:0] id_q, id_n;
	logic [7:0] rem_q, rem_n;
	logic taken_q, taken_n;
	logic tls_q, tls_n, esni_q, esni_n;
	logic [1:0] st_q, st_n;
	logic [17:0] bs_q, bs_n;
	logic [7:0] held_q, held_n;

	always_comb begin
		logic [16:0] lpos, hpos;
		logic [15:0] hl, word;
		logic [17:0] t18, nxt;
		pos_n = pos_q; phase_n = phase_q; rl_n = rl_q; fcur_n = fcur_q;
		tot_n = tot_q; ecur_n = ecur_q; id_n = id_q; rem_n = rem_q; taken_n = taken_q;
		tls_n = tls_q; esni_n = esni_q; st_n = st_q; bs_n = bs_q; held_n = held_q;
		rec = '0;
		lpos = dtls_q ? 17'd11 : 17'd3;
		hpos = dtls_q ? 17'd13 : 17'd5;
		word = {held_q, b};
		hl = '0; t18 = '0; nxt = '0;
		if (phase_q == PH_HDR) begin
			if (pos_q == '0) begin
				if (plen < 16'd15 || b != CT_HANDSHAKE) begin
					st_n = ST_REJECT; phase_n = PH_DONE;
				end
			end else if (pos_q == lpos) begin
				held_n = b;
			end else if (pos_q == lpos + 17'd1) begin
				rl_n = word;
			end else if (pos_q == hpos) begin
				hl = rl_q + (dtls_q ? 16'd13 : 16'd5);
				if (hl > plen) hl = plen;
				rl_n = hl;
				if (hl > 16'd4 && b == HS_CLIENT_HELLO) begin
					if ((dtls_q ? 16'd67 : 16'd45) > plen) begin
						st_n = ST_REJECT; phase_n = PH_DONE;
					end else begin
						fcur_n = dtls_q ? 18'd65 : 18'd43;
						phase_n = PH_SID;
					end
				end else begin
					st_n = ST_REJECT; phase_n = PH_DONE;
				end
			end
		end else if (phase_q != PH_DONE && {1'b0, pos_q} == fcur_q) begin
			if (pos_q >= {1'b0, plen}) begin
				st_n = ST_TRUNC; phase_n = PH_DONE;
			end else begin
				case (phase_q)
					PH_SID: begin
						if ({1'b0, pos_q} + {10'd0, b} + 18'd2 > {2'b0, rl_q}) begin
							st_n = ST_REJECT; phase_n = PH_DONE;
						end else begin
							fcur_n = {1'b0, pos_q} + {10'd0, b} + 18'd1;
							phase_n = PH_CH;
						end
					end
					PH_CH, PH_EH, PH_IH, PH_LH, PH_NH: begin
						held_n = b;
						fcur_n = fcur_q + 18'd1;
						case (phase_q)
							PH_CH: phase_n = PH_CL;
							PH_EH: phase_n = PH_EL;
							PH_IH: phase_n = PH_IL;
							PH_LH: phase_n = PH_LL;
							default: phase_n = PH_NL;
						endcase
					end
					PH_CL: begin
						t18 = {1'b0, pos_q} + {2'b0, word};
						bs_n = t18;
						if (t18 > {2'b0, rl_q}) begin
							st_n = ST_REJECT; phase_n = PH_DONE;
						end else begin
							fcur_n = t18 + 18'd1; phase_n = PH_COMP;
						end
					end
					PH_COMP: begin
						t18 = bs_q + {10'd0, b} + 18'd2;
						bs_n = t18;
						if (t18 > {2'b0, rl_q}) begin
							st_n = ST_REJECT; phase_n = PH_DONE;
						end else begin
							fcur_n = t18; phase_n = PH_EH;
						end
					end
					PH_EL: begin
						tot_n = word;
						if ({2'b0, word} + bs_q > {2'b0, rl_q}) begin
							st_n = ST_REJECT; phase_n = PH_DONE;
						end else begin
							tls_n = 1'b1;
							ecur_n = 18'd2;
							if (detect_q || 18'd2 >= {2'b0, word}) begin
								st_n = ST_OK; phase_n = PH_DONE;
							end else begin
								fcur_n = bs_q + 18'd2; phase_n = PH_IH;
							end
						end
					end
					PH_IL: begin
						id_n = word; fcur_n = fcur_q + 18'd1; phase_n = PH_LH;
					end
					PH_LL: begin
						t18 = ecur_q + 18'd4;
						ecur_n = t18;
						if (id_q == EXT_SNI && !taken_q) begin
							fcur_n = bs_q + t18 + 18'd3; phase_n = PH_NH;
						end else begin
							if (id_q == EXT_ESNI) esni_n = 1'b1;
							nxt = t18 + {2'b0, word};
							ecur_n = nxt;
							if (nxt >= {2'b0, tot_q}) begin
								st_n = ST_OK; phase_n = PH_DONE;
							end else begin
								fcur_n = bs_q + nxt; phase_n = PH_IH;
							end
						end
					end
					PH_NL: begin
						t18 = ecur_q + 18'd5;
						ecur_n = t18;
						if (word > 16'(NAME_MAX)) begin
							st_n = ST_REJECT; phase_n = PH_DONE;
						end else if (word == '0) begin
							if (t18 >= {2'b0, tot_q}) begin
								st_n = ST_OK; phase_n = PH_DONE;
							end else begin
								fcur_n = bs_q + t18; phase_n = PH_IH;
							end
						end else if (bs_q + t18 + {2'b0, word} > {2'b0, plen}) begin
							st_n = ST_TRUNC; phase_n = PH_DONE;
						end else begin
							rem_n = word[7:0];
							fcur_n = bs_q + t18; phase_n = PH_NAME;
						end
					end
					PH_NAME: begin
						rem_n = rem_q - 8'd1;
						nxt = ecur_q + 18'd1;
						ecur_n = nxt;
						rec.name_v = 1'b1;
						rec.name_char = b;
						rec.name_end = (rem_n == '0);
						if (rem_n == '0) begin
							taken_n = 1'b1;
							if (nxt >= {2'b0, tot_q}) begin
								st_n = ST_OK; phase_n = PH_DONE;
							end else begin
								fcur_n = bs_q + nxt; phase_n = PH_IH;
							end
						end else begin
							fcur_n = fcur_q + 18'd1;
						end
					end
					default: begin
						st_n = ST_TRUNC; phase_n = PH_DONE;
					end
				endcase
			end
		end
		if (pos_q != POS_MAX) pos_n = pos_q + 17'd1;
		if (last) begin
			if (phase_n != PH_DONE) st_n = ST_TRUNC;
			rec.verd_v = 1'b1;
			rec.tls = tls_n;
			rec.esni = esni_n;
			rec.status = st_n;
			pos_n = '0; phase_n = PH_HDR; rl_n = '0; fcur_n = '0; tot_n = '0;
			ecur_n = 18'd2; id_n = '0; rem_n = '0; taken_n = 1'b0;
			tls_n = 1'b0; esni_n = 1'b0; st_n = ST_OK; bs_n = '0; held_n = '0;
		end
	end

	assign rec_push = in_fire && (rec.name_v || rec.verd_v);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dtls_q <= 1'b0; detect_q <= 1'b0;
			pos_q <= '0; phase_q <= PH_HDR; rl_q <= '0; fcur_q <= '0; tot_q <= '0;
			ecur_q <= 18'd2; id_q <= '0; rem_q <= '0; taken_q <= 1'b0;
			tls_q <= 1'b0; esni_q <= 1'b0; st_q <= ST_OK; bs_q <= '0; held_q <= '0;
		end else begin
			if (cfg_fire && cfg_index == REG_DTLS) dtls_q <= cfg_data;
			if (cfg_fire && cfg_index == REG_DETECT) detect_q <= cfg_data;
			if (in_fire) begin
				pos_q <= pos_n; phase_q <= phase_n; rl_q <= rl_n; fcur_q <= fcur_n;
				tot_q <= tot_n; ecur_q <= ecur_n; id_q <= id_n; rem_q <= rem_n;
				taken_q <= taken_n; tls_q <= tls_n; esni_q <= esni_n; st_q <= st_n;
				bs_q <= bs_n; held_q <= held_n;
			end
		end
	end
endmodule

// ===== rtl/tcsx_queue.sv =====
// Two-entry record queue between parser and output side.
module tcsx_queue import tcsx_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  rec_t    din,
	input  logic    pop,
	output rec_t    head,
	output q_stat_t stat
);
	rec_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;

	assign stat.full = (cnt_q == 2'd2);
	assign stat.empty = (cnt_q == 2'd0);
	assign head = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

// ===== rtl/tcsx_back.sv =====
// Output side: turns each queued record into one or two stream words.
module tcsx_back import tcsx_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  rec_t        head,
	input  q_stat_t     stat,
	output logic        pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,
	output logic        m_tuser,
	output logic        m_tlast
);
	logic name_done_q;
	logic show_name;

	assign show_name = head.name_v && !name_done_q;
	assign m_tvalid = !stat.empty;
	assign m_tuser = show_name ? KIND_NAME : KIND_VERDICT;
	assign m_tlast = show_name ? !head.verd_v : 1'b1;
	assign m_tdata = show_name ? {7'd0, head.name_end, head.name_char}
	                           : {3'd0, head.status, head.esni, head.tls, 9'd0};
	assign pop = m_tvalid && m_tready && !(show_name && head.verd_v);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			name_done_q <= 1'b0;
		end else if (m_tvalid && m_tready) begin
			name_done_q <= show_name && head.verd_v;
		end
	end
endmodule

// ===== test/tb_tls_client_hello_sni_extractor_top.sv =====
// Testbench for the TLS ClientHello SNI extractor: table, random packets, self-checking predictor.
module tb_tls_client_hello_sni_extractor_top;
	import tcsx_pkg::*;

	localparam int LIMIT = 400000;
	localparam int ITEMS = 1050;

	localparam int K_GOOD = 0;
	localparam int K_EMPTY2 = 1;
	localparam int K_LONG = 2;
	localparam int K_NOISE = 3;
	localparam int K_FLIP = 4;
	localparam int K_TRUNC = 5;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;  // payload_byte[7:0], packet_len[23:8]
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;  // name_char, name_end, tls_seen, esni_seen, verdict_status
	logic        m_tuser;  // item_kind
	logic        m_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic        cfg_data = 1'b0;

	tls_client_hello_sni_extractor_top uut (.*);

	always #5 clk = ~clk;

	typedef struct {
		logic       kind;
		logic [7:0] ch;
		logic       nend;
		logic       tls;
		logic       esni;
		logic [1:0] st;
		logic       lst;
	} word_t;

	typedef struct {
		logic [7:0]  b;
		logic [15:0] plen;
		logic        lst;
		logic        typed;
		logic [1:0]  st;
	} row_t;

	word_t expected_words[$];
	int errors = 0;
	int cycles = 0;
	int sent = 0;
	bit calm = 0;
	logic [7:0] pkt[$];

	// predictor state
	logic cur_dtls, cur_detect;
	int unsigned p_pos, p_rl, p_cur, p_etot, p_ecur, p_eid, p_elen, p_nrem, p_bs, p_hi;
	phase_t p_ph;
	logic p_taken, p_tls, p_esni;
	logic [1:0] p_st;

	function automatic void clear_parse();
		p_pos = 0; p_ph = PH_HDR; p_rl = 0; p_cur = 0; p_etot = 0; p_ecur = 2;
		p_eid = 0; p_elen = 0; p_nrem = 0; p_taken = 0; p_tls = 0; p_esni = 0;
		p_st = ST_OK; p_bs = 0; p_hi = 0;
	endfunction

	function automatic void stop_parse(logic [1:0] st);
		p_st = st;
		p_ph = PH_DONE;
	endfunction

	function automatic void next_ext();
		if (p_ecur >= p_etot) stop_parse(ST_OK);
		else begin
			p_cur = p_bs + p_ecur;
			p_ph = PH_IH;
		end
	endfunction

	function automatic void predict_byte(logic [7:0] b8, logic [15:0] pl, logic lst);
		int unsigned b, plen, pos, lpos, hpos, hl, base, v;
		word_t w;
		b = b8; plen = pl; pos = p_pos;
		lpos = cur_dtls ? 11 : 3;
		hpos = cur_dtls ? 13 : 5;
		if (p_ph == PH_HDR) begin
			if (pos == 0) begin
				if (plen < 15 || b8 != CT_HANDSHAKE) stop_parse(ST_REJECT);
			end else if (pos == lpos) begin
				p_hi = b;
			end else if (pos == lpos + 1) begin
				p_rl = (p_hi << 8) | b;
			end else if (pos == hpos) begin
				hl = (p_rl + (cur_dtls ? 13 : 5)) & 32'hffff;
				if (hl > plen) hl = plen;
				p_rl = hl;
				if (hl > 4 && b8 == HS_CLIENT_HELLO) begin
					base = cur_dtls ? 65 : 43;
					if (base + 2 > plen) stop_parse(ST_REJECT);
					else begin
						p_cur = base;
						p_ph = PH_SID;
					end
				end else stop_parse(ST_REJECT);
			end
		end else if (p_ph != PH_DONE && pos == p_cur) begin
			if (pos >= plen) stop_parse(ST_TRUNC);
			else begin
				case (p_ph)
					PH_SID: begin
						if (b + pos + 2 > p_rl) stop_parse(ST_REJECT);
						else begin
							p_cur = pos + b + 1;
							p_ph = PH_CH;
						end
					end
					PH_CH, PH_EH, PH_IH, PH_LH, PH_NH: begin
						p_hi = b;
						p_cur++;
						p_ph = phase_t'(p_ph + 1);
					end
					PH_CL: begin
						p_bs = pos + ((p_hi << 8) | b);
						if (p_bs > p_rl) stop_parse(ST_REJECT);
						else begin
							p_cur = p_bs + 1;
							p_ph = PH_COMP;
						end
					end
					PH_COMP: begin
						p_bs += b + 2;
						if (p_bs > p_rl) stop_parse(ST_REJECT);
						else begin
							p_cur = p_bs;
							p_ph = PH_EH;
						end
					end
					PH_EL: begin
						p_etot = (p_hi << 8) | b;
						if (p_etot + p_bs > p_rl) stop_parse(ST_REJECT);
						else begin
							p_tls = 1;
							if (cur_detect) stop_parse(ST_OK);
							else begin
								p_ecur = 2;
								next_ext();
							end
						end
					end
					PH_IL: begin
						p_eid = (p_hi << 8) | b;
						p_cur++;
						p_ph = PH_LH;
					end
					PH_LL: begin
						p_elen = (p_hi << 8) | b;
						p_ecur += 4;
						if (p_eid == EXT_SNI && !p_taken) begin
							p_cur = p_bs + p_ecur + 3;
							p_ph = PH_NH;
						end else begin
							if (p_eid == EXT_ESNI) p_esni = 1;
							p_ecur += p_elen;
							next_ext();
						end
					end
					PH_NL: begin
						v = (p_hi << 8) | b;
						p_ecur += 5;
						if (v > NAME_MAX) stop_parse(ST_REJECT);
						else if (v == 0) next_ext();
						else if (p_bs + p_ecur + v > plen) stop_parse(ST_TRUNC);
						else begin
							p_nrem = v;
							p_cur = p_bs + p_ecur;
							p_ph = PH_NAME;
						end
					end
					PH_NAME: begin
						p_nrem--;
						p_ecur++;
						w = '{KIND_NAME, b8, p_nrem == 0, 0, 0, ST_OK, !lst};
						expected_words.push_back(w);
						if (p_nrem == 0) begin
							p_taken = 1;
							next_ext();
						end else p_cur++;
					end
					default: stop_parse(ST_TRUNC);
				endcase
			end
		end
		if (p_pos < POS_MAX) p_pos++;
		if (lst) begin
			if (p_ph != PH_DONE) stop_parse(ST_TRUNC);
			w = '{KIND_VERDICT, 8'd0, 0, p_tls, p_esni, p_st, 1};
			expected_words.push_back(w);
			clear_parse();
		end
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0h expected %0h", what, got, want);
		errors++;
	endtask

	// result checker
	always @(posedge clk) begin
		word_t w;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_words.size() == 0) report_mismatch("unexpected word", m_tdata, 0);
			else begin
				w = expected_words.pop_front();
				if (m_tuser !== w.kind) report_mismatch("item_kind", m_tuser, w.kind);
				if (m_tdata[7:0] !== w.ch) report_mismatch("name_char", m_tdata[7:0], w.ch);
				if (m_tdata[8] !== w.nend) report_mismatch("name_end", m_tdata[8], w.nend);
				if (m_tdata[9] !== w.tls) report_mismatch("tls_seen", m_tdata[9], w.tls);
				if (m_tdata[10] !== w.esni) report_mismatch("esni_seen", m_tdata[10], w.esni);
				if (m_tdata[12:11] !== w.st) report_mismatch("status", m_tdata[12:11], w.st);
				if (m_tdata[15:13] !== 3'b0) report_mismatch("pad", m_tdata[15:13], 0);
				if (m_tlast !== w.lst) report_mismatch("last_result", m_tlast, w.lst);
			end
		end
	end

	// receiver stalls in bursts
	always @(posedge clk) begin
		int stall;
		if (!calm && $urandom_range(0, 5) == 0) begin
			stall = $urandom_range(1, 11);
			m_tready <= 1'b0;
			repeat (stall) @(posedge clk);
		end
		m_tready <= 1'b1;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic send_byte(logic [7:0] b, logic [15:0] plen, logic lst,
			logic typed = 0, logic [1:0] st = ST_OK);
		word_t w;
		if (!calm && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {plen, b};
		s_tlast <= lst;
		do @(posedge clk); while (!s_tready);
		if (typed) begin
			// one-byte packet: verdict is easy to read off by hand
			w = '{KIND_VERDICT, 8'd0, 0, 0, 0, st, 1};
			expected_words.push_back(w);
			clear_parse();
		end else predict_byte(b, plen, lst);
		sent++;
	endtask

	task automatic write_cfg(logic [1:0] idx, logic val);
		s_tvalid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_DTLS) cur_dtls = val;
		else cur_detect = val;
	endtask

	function automatic void add_sni(int len);
		pkt.push_back(8'h00); pkt.push_back(8'h00);
		pkt.push_back(8'((len + 5) >> 8)); pkt.push_back(8'(len + 5));
		pkt.push_back(8'((len + 3) >> 8)); pkt.push_back(8'(len + 3));
		pkt.push_back(8'h00);
		pkt.push_back(8'(len >> 8)); pkt.push_back(8'(len));
		repeat (len) pkt.push_back(8'($urandom_range(8'h61, 8'h7a)));
	endfunction

	function automatic void add_ext(logic [15:0] id);
		int n;
		n = $urandom_range(0, 4);
		pkt.push_back(id[15:8]); pkt.push_back(id[7:0]);
		pkt.push_back(8'h00); pkt.push_back(8'(n));
		repeat (n) pkt.push_back(8'($urandom));
	endfunction

	task automatic send_packet(int kind);
		int base, lpos, hpos, et, rl, n, plen, cnt;
		pkt.delete();
		if (kind == K_NOISE) begin
			n = $urandom_range(1, 30);
			repeat (n) pkt.push_back(8'($urandom));
			if ($urandom_range(0, 1)) pkt[0] = CT_HANDSHAKE;
			plen = $urandom_range(0, 1) ? $urandom_range(0, 65535) : n;
		end else begin
			base = cur_dtls ? 65 : 43;
			lpos = cur_dtls ? 11 : 3;
			hpos = cur_dtls ? 13 : 5;
			while (pkt.size() < base) pkt.push_back(8'($urandom));
			pkt[0] = CT_HANDSHAKE;
			pkt[hpos] = HS_CLIENT_HELLO;
			n = $urandom_range(0, 4);
			pkt.push_back(8'(n));
			repeat (n) pkt.push_back(8'($urandom));
			n = 2 * $urandom_range(1, 2);
			pkt.push_back(8'h00); pkt.push_back(8'(n));
			repeat (n) pkt.push_back(8'($urandom));
			pkt.push_back(8'h01); pkt.push_back(8'h00);
			et = pkt.size();
			pkt.push_back(8'h00); pkt.push_back(8'h00);
			case (kind)
				K_EMPTY2: begin
					add_sni(0);
					add_sni($urandom_range(1, 8));
				end
				K_LONG: add_sni($urandom_range(0, 1) ? NAME_MAX : NAME_MAX + 1);
				default: begin
					cnt = $urandom_range(0, 3);
					repeat (cnt) begin
						case ($urandom_range(0, 2))
							0: add_sni($urandom_range(1, 12));
							1: add_ext(EXT_ESNI);
							default: add_ext(16'($urandom_range(1, 65535)));
						endcase
					end
				end
			endcase
			n = pkt.size() - et - 2;
			pkt[et] = 8'(n >> 8); pkt[et + 1] = 8'(n);
			rl = pkt.size() - (cur_dtls ? 13 : 5);
			pkt[lpos] = 8'(rl >> 8); pkt[lpos + 1] = 8'(rl);
			plen = pkt.size();
			if (kind == K_FLIP) pkt[$urandom_range(0, pkt.size() - 1)] = 8'($urandom);
			if (kind == K_TRUNC) begin
				case ($urandom_range(0, 2))
					0: plen = $urandom_range(0, pkt.size() - 1);
					1: plen = $urandom_range(pkt.size(), 65535);
					default: repeat ($urandom_range(1, 20)) void'(pkt.pop_back());
				endcase
			end
		end
		foreach (pkt[i]) send_byte(pkt[i], 16'(plen), i == pkt.size() - 1);
	endtask

	row_t rows[$] = '{
		'{8'h16, 16'd0, 1, 1, ST_REJECT},
		'{8'h16, 16'd14, 1, 1, ST_REJECT},
		'{8'hff, 16'hffff, 1, 1, ST_REJECT},
		'{8'h00, 16'd15, 1, 1, ST_REJECT},
		'{8'h16, 16'hffff, 1, 1, ST_TRUNC},
		'{8'h16, 16'd15, 1, 1, ST_TRUNC},
		'{8'h16, 16'd20, 0, 0, ST_OK},
		'{8'h03, 16'd20, 0, 0, ST_OK},
		'{8'h01, 16'd20, 0, 0, ST_OK},
		'{8'h00, 16'd20, 0, 0, ST_OK},
		'{8'h0f, 16'd20, 0, 0, ST_OK},
		'{8'h01, 16'd20, 1, 0, ST_OK}
	};

	initial begin
		int k;
		cur_dtls = 0; cur_detect = 0;
		clear_parse();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_cfg(REG_DTLS, 0);
		write_cfg(REG_DETECT, 0);
		foreach (rows[i]) send_byte(rows[i].b, rows[i].plen, rows[i].lst, rows[i].typed,
			rows[i].st);
		for (int m = 0; m < 4; m++) begin
			write_cfg(REG_DTLS, m[0]);
			write_cfg(REG_DETECT, m[1]);
			send_packet(K_GOOD);
			send_packet(K_EMPTY2);
			if (m == 0) begin
				send_packet(K_LONG);
				send_packet(K_TRUNC);
			end
		end
		k = 0;
		while (sent < ITEMS) begin
			if (k % 8 == 7) begin
				write_cfg($urandom_range(0, 1) ? REG_DTLS : REG_DETECT, $urandom_range(0, 3) == 0);
			end
			if (sent > ITEMS - 150) calm = 1;
			case ($urandom_range(0, 11))
				0: send_packet(K_NOISE);
				1: send_packet(K_FLIP);
				2: send_packet(K_TRUNC);
				3: send_packet(K_LONG);
				4: send_packet(K_EMPTY2);
				default: send_packet(K_GOOD);
			endcase
			k++;
		end
		s_tvalid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0) $display("Verification passed");
		else $display("Verification failed");
		$finish;
	end
endmodule
